// File: rtl/b32e_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b32e_pkg
// Shared types, constants and the symbol lookup for the base32 encoder.
// ----------------------------------------------------------------------------
package b32e_pkg;

  localparam int unsigned GROUP_W    = 5;
  localparam int unsigned ACC_W      = 13;  // up to 4 leftover bits plus one byte
  localparam int unsigned LEFT_W     = 4;
  localparam int unsigned LEFT_CNT_W = 3;
  localparam int unsigned CHAR_W     = 7;

  localparam logic [GROUP_W-1:0] NUM_LETTERS = 5'd26;
  localparam logic [CHAR_W-1:0]  CHAR_LOW_A  = 7'h61;  // 'a'
  localparam logic [CHAR_W-1:0]  CHAR_LOW_Z  = 7'h7a;  // 'z'
  localparam logic [CHAR_W-1:0]  CHAR_DIG_2  = 7'h32;  // '2'
  localparam logic [CHAR_W-1:0]  CHAR_DIG_7  = 7'h37;  // '7'

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_message;
  } in_word_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              last_char;
  } out_word_t;

  // Groups of one byte waiting to be emitted, lowest group first.
  typedef struct packed {
    logic [ACC_W-1:0] bits;
    logic [1:0]       count;
    logic             eom;
  } group_t;

  function automatic logic [CHAR_W-1:0] symbol_of(input logic [GROUP_W-1:0] v);
    logic [CHAR_W-1:0] code;
    if (v < NUM_LETTERS) begin
      code = CHAR_LOW_A + {2'b00, v};
    end else begin
      code = CHAR_DIG_2 + {2'b00, v - NUM_LETTERS};
    end
    return code;
  endfunction

endpackage
`default_nettype wire

// File: rtl/b32e_split.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b32e_split
// Merges each byte with the leftover bits and cuts it into 5-bit groups.
// ----------------------------------------------------------------------------
module b32e_split (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire b32e_pkg::in_word_t in_word,
  input  wire logic               take,
  output b32e_pkg::group_t        grp
);
  import b32e_pkg::*;

  logic [LEFT_W-1:0]     leftover_bits;
  logic [LEFT_CNT_W-1:0] leftover_count;
  logic [LEFT_W-1:0]     leftover_bits_next;
  logic [LEFT_CNT_W-1:0] leftover_count_next;

  logic [ACC_W-1:0] acc;
  logic [3:0]       bit_total;
  logic             two_groups;
  logic [2:0]       rest;
  logic             tail;

  always_comb begin
    // place the new byte above the leftover bits
    acc        = {{(ACC_W-LEFT_W){1'b0}}, leftover_bits}
               | ({5'b00000, in_word.data_byte} << leftover_count);
    bit_total  = {1'b0, leftover_count} + 4'd8;
    two_groups = (bit_total >= 4'd10);
    rest       = two_groups ? 3'(bit_total - 4'd10) : 3'(bit_total - 4'd5);
    tail       = in_word.end_of_message && (rest != 3'd0);

    grp.bits  = acc;
    grp.count = (two_groups ? 2'd2 : 2'd1) + {1'b0, tail};
    grp.eom   = in_word.end_of_message;

    if (in_word.end_of_message) begin
      leftover_bits_next  = '0;
      leftover_count_next = '0;
    end else begin
      leftover_bits_next  = two_groups ? {1'b0, acc[12:10]} : acc[8:5];
      leftover_count_next = rest;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      leftover_bits  <= '0;
      leftover_count <= '0;
    end else if (take) begin
      leftover_bits  <= leftover_bits_next;
      leftover_count <= leftover_count_next;
    end
  end

endmodule
`default_nettype wire

// File: rtl/b32e_emit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b32e_emit
// Holds the groups of one byte and sends them out one character per cycle while out_ready allows.
// ----------------------------------------------------------------------------
module b32e_emit (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire b32e_pkg::group_t  grp,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output b32e_pkg::out_word_t    out_word
);
  import b32e_pkg::*;

  group_t hold;
  logic   out_load;
  logic   take;

  assign out_load = (hold.count != 2'd0) && (!out_valid || out_ready);
  // accept when no group is pending, or once the last pending group leaves this cycle
  assign in_ready = (hold.count == 2'd0) || ((hold.count == 2'd1) && out_load);
  assign take     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold.count <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (take) begin
        hold <= grp;
      end else if (out_load) begin
        hold.bits  <= hold.bits >> GROUP_W;
        hold.count <= hold.count - 2'd1;
      end
      if (out_load) begin
        out_valid          <= 1'b1;
        out_word.char_code <= symbol_of(hold.bits[GROUP_W-1:0]);
        out_word.last_char <= hold.eom && (hold.count == 2'd1);
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_take_nonempty: assert property (@(posedge clk) disable iff (rst)
    take |-> grp.count != 2'd0)
    else $error("byte taken with no groups to emit");

  a_ready_backlog: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> hold.count <= 2'd1)
    else $error("ready while more than one group pending");

  a_alphabet: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_word.char_code >= CHAR_LOW_A && out_word.char_code <= CHAR_LOW_Z)
                || (out_word.char_code >= CHAR_DIG_2 && out_word.char_code <= CHAR_DIG_7)))
    else $error("character outside alphabet");

  a_last_drains: assert property (@(posedge clk) disable iff (rst)
    out_load && hold.eom && hold.count == 2'd1 && !take |=> hold.count == 2'd0)
    else $error("groups left after final character");
`endif

endmodule
`default_nettype wire

// File: rtl/base32_lsb_first_encoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// base32_lsb_first_encoder
// Lowercase, unpadded base32 encoder taking byte bits least significant first.
// ----------------------------------------------------------------------------
// Each accepted byte yields one to three characters ('a'..'z', '2'..'7'); the
// output port sends one character per cycle while out_ready allows it, and a
// byte yields about 1.6 characters on average (2 for most bytes). The next
// byte is accepted in the cycle the previous byte's last character moves
// into the output register, so there are no bubbles between bytes. The
// final character of a message, including a zero-extended partial group,
// carries last_char.
module base32_lsb_first_encoder (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire b32e_pkg::in_word_t  in_word,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output b32e_pkg::out_word_t      out_word
);
  import b32e_pkg::*;

  group_t grp;

  b32e_split u_split (
    .clk     (clk),
    .rst     (rst),
    .in_word (in_word),
    .take    (in_valid && in_ready),
    .grp     (grp)
  );

  b32e_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .grp       (grp),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

endmodule
`default_nettype wire
